// ===== rtl/tvhp_pkg.sv =====
`default_nettype none

package tvhp_pkg;

    localparam int ACC_W = 44;
    localparam int KEY_W = 17;

    localparam logic [7:0] SEP_BYTE   = 8'h01;
    localparam logic [7:0] EQ_BYTE    = 8'h3D;
    localparam logic [7:0] PLUS_BYTE  = 8'h2B;
    localparam logic [7:0] MINUS_BYTE = 8'h2D;
    localparam logic [7:0] SPACE_BYTE = 8'h20;

    localparam logic [KEY_W-1:0] KEY_CAP   = 17'd65536;
    localparam logic [ACC_W-1:0] ACC_CAP   = {ACC_W{1'b1}};
    localparam logic [15:0]      MAX_PKG   = 16'hFFFF;
    localparam logic [16:0]      MAX_LEN   = 17'd99999;
    localparam logic [7:0]       MAX_CHAIN = 8'd255;
    localparam logic [ACC_W-1:0] MAX_SEQ   = 44'd9999999999999;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_KEY   = 2'd1,
        ST_BAD_VALUE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_TAG_PACKAGE       = 2'd0,
        CFG_TAG_BODY_LENGTH   = 2'd1,
        CFG_TAG_MESSAGE_CHAIN = 2'd2,
        CFG_TAG_SEQUENCE      = 2'd3
    } cfg_index_t;

    typedef enum logic [6:0] {
        PH_SKIP   = 7'b0000001,
        PH_KEY    = 7'b0000010,
        PH_LEAD   = 7'b0000100,
        PH_DIGITS = 7'b0001000,
        PH_TAIL   = 7'b0010000,
        PH_BAD    = 7'b0100000,
        PH_DONE   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [15:0] tag_package;
        logic [15:0] tag_body_length;
        logic [15:0] tag_message_chain;
        logic [15:0] tag_sequence;
    } tag_set_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_header;
    } byte_item_t;

    typedef struct packed {
        logic [15:0]      package_id;
        logic [16:0]      body_length;
        logic [7:0]       message_chain;
        logic [ACC_W-1:0] sequence_number;
        logic [3:0]       seen_mask;
        logic [1:0]       parse_status;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/tvhp_parse_core.sv =====
`default_nettype none

module tvhp_parse_core
    import tvhp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire byte_item_t item,
    input  wire tag_set_t tags,
    output result_t       result
);

    phase_t           phase_reg, phase_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             key_ended_reg, key_ended_next;
    logic             digit_reg, digit_next;
    logic [15:0]      pkg_reg, pkg_next;
    logic [16:0]      len_reg, len_next;
    logic [7:0]       chain_reg, chain_next;
    logic [ACC_W-1:0] seq_reg, seq_next;
    logic [3:0]       seen_reg, seen_next;
    logic [1:0]       status_reg, status_next;

    logic [7:0]       b;
    logic             is_dec, is_hex, is_ws, is_sign, hex_mode, is_dig, take_digit;
    logic [3:0]       dval;
    logic [3:0]       tgt_hit;
    logic [20:0]      key_prod;
    logic [ACC_W+3:0] acc_prod;

    assign b = item.data_byte;

    // priority of the key compare: package, length, chain, sequence
    assign tgt_hit[0] = (key_reg == {1'b0, tags.tag_package});
    assign tgt_hit[1] = !tgt_hit[0] && (key_reg == {1'b0, tags.tag_body_length});
    assign tgt_hit[2] = !(|tgt_hit[1:0]) && (key_reg == {1'b0, tags.tag_message_chain});
    assign tgt_hit[3] = !(|tgt_hit[2:0]) && (key_reg == {1'b0, tags.tag_sequence});

    assign hex_mode = tgt_hit[0];
    assign is_dec   = (b >= 8'h30) && (b <= 8'h39);
    assign is_hex   = is_dec || ((b >= 8'h61) && (b <= 8'h66))
                      || ((b >= 8'h41) && (b <= 8'h46));
    assign is_dig   = hex_mode ? is_hex : is_dec;
    assign is_ws    = (b == SPACE_BYTE) || ((b >= 8'h09) && (b <= 8'h0D));
    assign is_sign  = (b == PLUS_BYTE) || (b == MINUS_BYTE);

    always_comb
    begin
        if (is_dec)
            dval = b[3:0];
        else if (b >= 8'h61)
            dval = 4'(b - 8'h57);
        else
            dval = 4'(b - 8'h37);
    end

    assign key_prod = {key_reg, 3'b000} + {2'b00, key_reg, 1'b0} + {17'd0, b[3:0]};

    // saturate when the shifted sum spills past the accumulator width
    assign acc_prod = hex_mode ? {acc_reg, 4'b0000}
                    : ({1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}) + {44'd0, dval};

    logic [ACC_W+3:0] acc_sum;
    assign acc_sum = hex_mode ? ({acc_reg, 4'b0000} + {44'd0, dval}) : acc_prod;

    always_comb
    begin
        phase_next     = phase_reg;
        key_next       = key_reg;
        acc_next       = acc_reg;
        key_ended_next = key_ended_reg;
        digit_next     = digit_reg;
        pkg_next       = pkg_reg;
        len_next       = len_reg;
        chain_next     = chain_reg;
        seq_next       = seq_reg;
        seen_next      = seen_reg;
        status_next    = status_reg;
        take_digit     = 1'b0;

        case (phase_reg)
            PH_SKIP:
                phase_next = PH_KEY;
            PH_KEY:
            begin
                if (b == SEP_BYTE)
                    phase_next = PH_DONE;
                else if (b == EQ_BYTE)
                begin
                    phase_next = PH_LEAD;
                    acc_next   = '0;
                    digit_next = 1'b0;
                end
                else if (!key_ended_reg && is_dec)
                    key_next = (key_prod > {4'd0, KEY_CAP}) ? KEY_CAP : key_prod[KEY_W-1:0];
                else
                    key_ended_next = 1'b1;
            end
            PH_LEAD, PH_DIGITS, PH_TAIL, PH_BAD:
            begin
                if (b == SEP_BYTE)
                begin
                    if (tgt_hit == 4'b0000)
                    begin
                        status_next = ST_BAD_KEY;
                        phase_next  = PH_DONE;
                    end
                    else if ((phase_reg == PH_BAD) || (tgt_hit[0] && !digit_reg))
                    begin
                        status_next = ST_BAD_VALUE;
                        phase_next  = PH_DONE;
                    end
                    else
                    begin
                        if (tgt_hit[0])
                            pkg_next = (acc_reg > 44'(MAX_PKG)) ? MAX_PKG : acc_reg[15:0];
                        if (tgt_hit[1])
                            len_next = (acc_reg > 44'(MAX_LEN)) ? MAX_LEN : acc_reg[16:0];
                        if (tgt_hit[2])
                            chain_next = (acc_reg > 44'(MAX_CHAIN)) ? MAX_CHAIN : acc_reg[7:0];
                        if (tgt_hit[3])
                            seq_next = (acc_reg > MAX_SEQ) ? MAX_SEQ : acc_reg;
                        seen_next      = seen_reg | tgt_hit;
                        phase_next     = PH_KEY;
                        key_next       = '0;
                        acc_next       = '0;
                        key_ended_next = 1'b0;
                        digit_next     = 1'b0;
                    end
                end
                else if (phase_reg == PH_LEAD)
                begin
                    if (is_sign)
                        phase_next = PH_BAD;
                    else if (!is_ws)
                        take_digit = 1'b1;
                end
                else if (phase_reg == PH_DIGITS)
                    take_digit = 1'b1;

                if (take_digit)
                begin
                    if (is_dig)
                    begin
                        acc_next   = (acc_sum[ACC_W+3:ACC_W] != 4'd0) ? ACC_CAP
                                                                     : acc_sum[ACC_W-1:0];
                        digit_next = 1'b1;
                        phase_next = PH_DIGITS;
                    end
                    else
                        phase_next = PH_TAIL;
                end
            end
            default:
                ;
        endcase
    end

    // result reflects the state after the marked byte is parsed
    assign result.package_id      = pkg_next;
    assign result.body_length     = len_next;
    assign result.message_chain   = chain_next;
    assign result.sequence_number = seq_next;
    assign result.seen_mask       = seen_next;
    assign result.parse_status    = status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            key_reg       <= '0;
            acc_reg       <= '0;
            key_ended_reg <= 1'b0;
            digit_reg     <= 1'b0;
            pkg_reg       <= '0;
            len_reg       <= '0;
            chain_reg     <= '0;
            seq_reg       <= '0;
            seen_reg      <= '0;
            status_reg    <= ST_OK;
        end
        else if (step)
        begin
            if (item.end_of_header)
            begin
                phase_reg     <= PH_SKIP;
                key_reg       <= '0;
                acc_reg       <= '0;
                key_ended_reg <= 1'b0;
                digit_reg     <= 1'b0;
                pkg_reg       <= '0;
                len_reg       <= '0;
                chain_reg     <= '0;
                seq_reg       <= '0;
                seen_reg      <= '0;
                status_reg    <= ST_OK;
            end
            else
            begin
                phase_reg     <= phase_next;
                key_reg       <= key_next;
                acc_reg       <= acc_next;
                key_ended_reg <= key_ended_next;
                digit_reg     <= digit_next;
                pkg_reg       <= pkg_next;
                len_reg       <= len_next;
                chain_reg     <= chain_next;
                seq_reg       <= seq_next;
                seen_reg      <= seen_next;
                status_reg    <= status_next;
            end
        end
    end

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.end_of_header |=> phase_reg == PH_SKIP && seen_reg == 4'd0)
        else $error("header end did not restart the parser");

    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg != ST_OK |-> phase_reg == PH_DONE)
        else $error("error status recorded while parsing continues");

    a_seen_kept: assert property (@(posedge clk) disable iff (!rst_n)
        $past(step) && !$past(item.end_of_header)
        |-> (seen_reg & $past(seen_reg)) == $past(seen_reg))
        else $error("seen mask lost a bit inside a header");

endmodule

`default_nettype wire

// ===== rtl/tvhp_out_reg.sv =====
`default_nettype none

module tvhp_out_reg
    import tvhp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t load_data,
    input  wire logic    result_stall,
    output logic         free,
    output logic         result_valid,
    output result_t      result_data
);

    logic    vld_reg;
    result_t data_reg;

    assign free         = !vld_reg || !result_stall;
    assign result_valid = vld_reg;
    assign result_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (load)
            vld_reg <= 1'b1;
        else if (!result_stall)
            vld_reg <= 1'b0;
    end

    // hold the result until the request is taken
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

endmodule

`default_nettype wire

// ===== rtl/tag_value_header_parser_unit.sv =====
`default_nettype none

// Flow: an accepted byte waits in the input register and is parsed when it fires;
// a result is loaded into the output register when its end_of_header byte fires.
// Throughput: one byte per cycle, set by the combinational parse step between
// the input register and the parser state; the input stalls only while a
// finished result is held and another header end is waiting.
// Reset: rst_n clears all control state and restores the default key numbers.
module tag_value_header_parser_unit
    import tvhp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_stall,
    input  wire byte_item_t byte_data,
    output logic            result_valid,
    input  wire logic       result_stall,
    output result_t         result_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic       in_vld_reg;
    byte_item_t in_item_reg;
    logic       out_free;
    logic       fire;
    logic       byte_take;
    tag_set_t   tags_reg;
    result_t    core_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tags_reg.tag_package       <= 16'd1;
            tags_reg.tag_body_length   <= 16'd2;
            tags_reg.tag_message_chain <= 16'd3;
            tags_reg.tag_sequence      <= 16'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TAG_PACKAGE:       tags_reg.tag_package       <= cfg_data;
                CFG_TAG_BODY_LENGTH:   tags_reg.tag_body_length   <= cfg_data;
                CFG_TAG_MESSAGE_CHAIN: tags_reg.tag_message_chain <= cfg_data;
                CFG_TAG_SEQUENCE:      tags_reg.tag_sequence      <= cfg_data;
                default:               ;
            endcase
        end
    end

    // advance unless a header end would overwrite a result still waiting
    assign fire       = in_vld_reg && (!in_item_reg.end_of_header || out_free);
    assign byte_stall = in_vld_reg && !fire;
    assign byte_take  = byte_valid && !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (byte_take)
            in_vld_reg <= 1'b1;
        else if (fire)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (byte_take)
            in_item_reg <= byte_data;
    end

    tvhp_parse_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (fire),
        .item   (in_item_reg),
        .tags   (tags_reg),
        .result (core_result)
    );

    tvhp_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire && in_item_reg.end_of_header),
        .load_data    (core_result),
        .result_stall (result_stall),
        .free         (out_free),
        .result_valid (result_valid),
        .result_data  (result_data)
    );

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_item_reg.end_of_header |=> result_valid)
        else $error("header end produced no result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> result_valid && result_stall && in_item_reg.end_of_header)
        else $error("input stalled without a blocked result");

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> !byte_stall)
        else $error("input stalled with an empty input register");

endmodule

`default_nettype wire
